/* rtl/abrb_pkg.sv */
package abrb_pkg;

	// Default width of stored versions and generations (8 to 64, stored at most 32 bits)
	localparam int VERSION_BITS_DEF = 32;

	// Fixed field widths on the ports
	localparam int FIELD_W    = 32;
	localparam int REQ_W      = 3;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 2;
	localparam int ATTEMPT_W  = 8;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 144;

	// Attempt limit after reset
	localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = 8'd3;

	// Request kinds
	localparam logic [REQ_W-1:0] REQ_STAGE      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SELECT     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SUCCESS    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FAILURE    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SAFE_ENTER = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SAFE_CLEAR = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DENIED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STORE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOPEND  = 3'd4;

	// Slot codes: pending slot and stage target
	localparam logic [SLOT_W-1:0] PEND_NONE = 2'd0;
	localparam logic [SLOT_W-1:0] PEND_A    = 2'd1;
	localparam logic [SLOT_W-1:0] PEND_B    = 2'd2;

	// Active / boot slot codes
	localparam logic SLOT_A = 1'b0;
	localparam logic SLOT_B = 1'b1;

endpackage

/* rtl/ab_boot_slot_rollback_controller_unit.sv */
// Channel  | direction | handshake         | payload
// s        | in        | s_tvalid/s_tready | s_tuser: req_type; s_tdata: request fields
// m        | out       | m_tvalid/m_tready | m_tdata: status, slots, state after request
// cfg      | in        | cfg_valid/cfg_ready | cfg_data: max_boot_attempts
//
// One item per cycle sustained while m is taking; a request passes the input register, then the result register.
// The slot state registers close their update loop in the decode stage, so a
// request sees the state left by the one before it in the next cycle.
// Reset clears all slot state and sets the attempt limit to 3.
// A stall on m holds the result register and backs up through the input
// register; s_tready drops only when both are full and m is not taking.
module ab_boot_slot_rollback_controller_unit #(
	parameter int VERSION_BITS = abrb_pkg::VERSION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request item
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [2:0] req_type
	input  logic [abrb_pkg::REQ_W-1:0]          s_tuser,
	// [1:0] target_slot, [33:2] new_version, [65:34] new_generation,
	// [66] manifest_ok, [67] auth_ok, [68] store_ok, [71:69] zero
	input  logic [abrb_pkg::IN_DATA_W-1:0]      s_tdata,
	// result item
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] status, [3] boot_slot, [4] active_now, [6:5] pending_now,
	// [38:7] confirmed_ver_out, [70:39] generation_out,
	// [102:71] pending_ver_out, [134:103] pending_gen_out,
	// [142:135] attempts_out, [143] safe_out
	output logic [abrb_pkg::OUT_DATA_W-1:0]     m_tdata,
	// attempt limit write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [abrb_pkg::ATTEMPT_W-1:0]      cfg_data
);
	import abrb_pkg::*;

	// Stored version width: the input fields carry at most FIELD_W bits
	localparam int VW = (VERSION_BITS < FIELD_W) ? VERSION_BITS : FIELD_W;

	// Attempt limit register
	logic [ATTEMPT_W-1:0] max_att_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= MAX_ATTEMPTS_RST;
		end else if (cfg_valid) begin
			max_att_q <= cfg_data;
		end
	end

	// Input register
	logic                 valid_s1;
	logic [REQ_W-1:0]     req_s1;
	logic [SLOT_W-1:0]    tgt_s1;
	logic [VW-1:0]        ver_s1;
	logic [VW-1:0]        gen_s1;
	logic                 man_s1;
	logic                 auth_s1;
	logic                 store_s1;
	logic                 fire_s1;
	logic                 s_fire;

	assign fire_s1  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || fire_s1;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_s1   <= s_tuser;
			tgt_s1   <= s_tdata[SLOT_W-1:0];
			ver_s1   <= s_tdata[2 +: VW];
			gen_s1   <= s_tdata[34 +: VW];
			man_s1   <= s_tdata[66];
			auth_s1  <= s_tdata[67];
			store_s1 <= s_tdata[68];
		end
	end

	// Slot state
	logic                 active_q;
	logic [SLOT_W-1:0]    pend_q;
	logic [VW-1:0]        cver_q;
	logic [VW-1:0]        cgen_q;
	logic [VW-1:0]        pver_q;
	logic [VW-1:0]        pgen_q;
	logic [ATTEMPT_W-1:0] att_q;
	logic                 safe_q;

	// Proposed next state
	logic                 nx_active;
	logic [SLOT_W-1:0]    nx_pend;
	logic [VW-1:0]        nx_cver;
	logic [VW-1:0]        nx_cgen;
	logic [VW-1:0]        nx_pver;
	logic [VW-1:0]        nx_pgen;
	logic [ATTEMPT_W-1:0] nx_att;
	logic                 nx_safe;
	logic [STATUS_W-1:0]  status;
	logic                 boot;
	logic                 do_store;
	logic                 commit;
	logic                 at_limit;

	assign at_limit = (att_q >= max_att_q);

	// Request decode
	always_comb begin
		nx_active = active_q;
		nx_pend   = pend_q;
		nx_cver   = cver_q;
		nx_cgen   = cgen_q;
		nx_pver   = pver_q;
		nx_pgen   = pgen_q;
		nx_att    = att_q;
		nx_safe   = safe_q;
		status    = ST_OK;
		boot      = SLOT_A;
		do_store  = 1'b0;
		case (req_s1)
			REQ_STAGE: begin
				if (!man_s1 || !(tgt_s1 == PEND_A || tgt_s1 == PEND_B) ||
				    ver_s1 == '0 || gen_s1 == '0) begin
					status = ST_INVALID;
				end else if (!auth_s1) begin
					status = ST_DENIED;
				end else if (tgt_s1[1] == active_q || ver_s1 <= cver_q ||
				             (pend_q != PEND_NONE && ver_s1 <= pver_q) ||
				             gen_s1 <= cgen_q) begin
					status = ST_INVALID;
				end else begin
					nx_pend  = tgt_s1;
					nx_pver  = ver_s1;
					nx_pgen  = gen_s1;
					nx_att   = '0;
					nx_safe  = 1'b0;
					do_store = 1'b1;
				end
			end
			REQ_SELECT: begin
				if (safe_q || pend_q == PEND_NONE) begin
					boot = active_q;
				end else begin
					if (at_limit) begin
						// roll back: drop the pending image, go safe
						nx_safe = 1'b1;
						nx_pend = PEND_NONE;
						nx_pver = '0;
						nx_pgen = '0;
						boot    = active_q;
					end else begin
						nx_att = att_q + 8'd1;
						boot   = pend_q[1];
					end
					do_store = 1'b1;
				end
			end
			REQ_SUCCESS: begin
				if (pend_q == PEND_NONE) begin
					status = ST_NOPEND;
				end else begin
					nx_active = pend_q[1];
					nx_cver   = pver_q;
					nx_cgen   = pgen_q;
					nx_pend   = PEND_NONE;
					nx_pver   = '0;
					nx_pgen   = '0;
					nx_att    = '0;
					nx_safe   = 1'b0;
					do_store  = 1'b1;
				end
			end
			REQ_FAILURE: begin
				if (pend_q == PEND_NONE) begin
					status = ST_NOPEND;
				end else begin
					if (at_limit) begin
						nx_safe = 1'b1;
						nx_pend = PEND_NONE;
						nx_pver = '0;
						nx_pgen = '0;
					end
					do_store = 1'b1;
				end
			end
			REQ_SAFE_ENTER: begin
				nx_safe  = 1'b1;
				nx_pend  = PEND_NONE;
				nx_pver  = '0;
				nx_pgen  = '0;
				do_store = 1'b1;
			end
			REQ_SAFE_CLEAR: begin
				nx_safe  = 1'b0;
				nx_att   = '0;
				do_store = 1'b1;
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
		// failed persistent write keeps the old state
		if (do_store && !store_s1) begin
			status = ST_STORE;
			boot   = SLOT_A;
		end
	end

	assign commit = do_store && store_s1;

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= SLOT_A;
			pend_q   <= PEND_NONE;
			cver_q   <= '0;
			cgen_q   <= '0;
			pver_q   <= '0;
			pgen_q   <= '0;
			att_q    <= '0;
			safe_q   <= 1'b0;
		end else if (fire_s1 && commit) begin
			active_q <= nx_active;
			pend_q   <= nx_pend;
			cver_q   <= nx_cver;
			cgen_q   <= nx_cgen;
			pver_q   <= nx_pver;
			pgen_q   <= nx_pgen;
			att_q    <= nx_att;
			safe_q   <= nx_safe;
		end
	end

	// Result register
	logic [OUT_DATA_W-1:0] res_data;
	logic [OUT_DATA_W-1:0] out_q;
	logic                  out_valid_q;

	always_comb begin
		if (commit) begin
			res_data = {nx_safe, nx_att, FIELD_W'(nx_pgen), FIELD_W'(nx_pver),
			            FIELD_W'(nx_cgen), FIELD_W'(nx_cver), nx_pend, nx_active,
			            boot, status};
		end else begin
			res_data = {safe_q, att_q, FIELD_W'(pgen_q), FIELD_W'(pver_q),
			            FIELD_W'(cgen_q), FIELD_W'(cver_q), pend_q, active_q,
			            boot, status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

/* rtl/abrb_chk.sv */
module abrb_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [abrb_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import abrb_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a slot is only reported by a select that went through
	a_boot_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == ST_OK)
		else $error("boot slot set on a non-ok result");

	// safe mode never coexists with a pending image
	a_safe_pend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[143] |-> m_tdata[6:5] == PEND_NONE &&
		m_tdata[102:71] == '0 && m_tdata[134:103] == '0)
		else $error("safe mode with pending image");

	// nothing pending means no pending version or generation
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:5] == PEND_NONE |->
		m_tdata[102:71] == '0 && m_tdata[134:103] == '0)
		else $error("stale pending version");

endmodule

bind ab_boot_slot_rollback_controller_unit abrb_chk u_abrb_chk (.*);
